// ----- design/lfe_pkg.sv -----
// Package: shared constants, command codes and sequencer types of the LED fade engine.
`default_nettype none

package lfe_pkg;

  localparam int MODE_W      = 3;
  localparam int TIME_W      = 32;
  localparam int FIELD_W     = 16;
  localparam int IO_CHANNELS = 4;

  // Command codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCHED  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RELAY  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_WAIT,
    S_DONE
  } lfe_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIX
  } lfe_unit_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lfe_unit_sts_t;

endpackage

`default_nettype wire

// ----- design/lfe_if.sv -----
// Interfaces: command channel and result channel of the LED fade engine.
`default_nettype none

interface lfe_cmd_if import lfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [TIME_W-1:0]  delay_ms;
  logic [TIME_W-1:0]  length_ms;
  logic [FIELD_W-1:0] level_desk_warm;
  logic [FIELD_W-1:0] level_desk_cold;
  logic [FIELD_W-1:0] level_ceil_warm;
  logic [FIELD_W-1:0] level_ceil_cold;
  logic               relay_on;

  modport source (
    output valid, mode, delay_ms, length_ms, level_desk_warm, level_desk_cold,
           level_ceil_warm, level_ceil_cold, relay_on,
    input  ready
  );
  modport sink (
    input  valid, mode, delay_ms, length_ms, level_desk_warm, level_desk_cold,
           level_ceil_warm, level_ceil_cold, relay_on,
    output ready
  );
endinterface

interface lfe_res_if import lfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] duty_desk_warm;
  logic [FIELD_W-1:0] duty_desk_cold;
  logic [FIELD_W-1:0] duty_ceil_warm;
  logic [FIELD_W-1:0] duty_ceil_cold;
  logic               relay_state;
  logic               fade_armed;

  modport source (
    output valid, duty_desk_warm, duty_desk_cold, duty_ceil_warm, duty_ceil_cold,
           relay_state, fade_armed,
    input  ready
  );
  modport sink (
    input  valid, duty_desk_warm, duty_desk_cold, duty_ceil_warm, duty_ceil_cold,
           relay_state, fade_armed,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/lfe_lerp_unit.sv -----
// Shared interpolation unit: one multiply, then a bit-serial restoring divide.
`default_nettype none

module lfe_lerp_unit import lfe_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TIME_W-1:0]     t_val,
  input  logic [TIME_W:0]       den,
  input  logic [LEVEL_BITS-1:0] s_lvl,
  input  logic [LEVEL_BITS-1:0] e_lvl,
  output lfe_unit_sts_t         sts,
  output logic [LEVEL_BITS-1:0] result
);

  localparam int CNT_W  = $clog2(LEVEL_BITS);
  localparam int PROD_W = TIME_W + LEVEL_BITS;

  lfe_unit_state_t state, state_next;

  logic                  up;
  logic [LEVEL_BITS-1:0] diff;
  logic [TIME_W:0]       rem;
  logic [LEVEL_BITS-1:0] quo;
  logic [CNT_W-1:0]      cnt;

  logic [PROD_W-1:0]     prod;
  logic [TIME_W+1:0]     shifted;
  logic [TIME_W+1:0]     trial;

  assign prod    = t_val * diff;
  assign shifted = {rem, quo[LEVEL_BITS-1]};
  assign trial   = shifted - {1'b0, den};

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE:  if (start) state_next = U_MUL;
      U_MUL:   state_next = U_DIV;
      U_DIV:   if (cnt == '0) state_next = U_FIX;
      U_FIX:   state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  // Rising fade adds the floored quotient; falling fade subtracts its ceiling
  always_comb begin
    sts.busy = (state != U_IDLE);
    sts.done = (state == U_FIX);
    if (up) begin
      result = s_lvl + quo;
    end else begin
      result = s_lvl - quo - LEVEL_BITS'(rem != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          up   <= (e_lvl >= s_lvl);
          diff <= (e_lvl >= s_lvl) ? (e_lvl - s_lvl) : (s_lvl - e_lvl);
        end
      end
      U_MUL: begin
        // high part stays below den because t < den and diff < 2**LEVEL_BITS
        rem <= {1'b0, prod[PROD_W-1:LEVEL_BITS]};
        quo <= prod[LEVEL_BITS-1:0];
        cnt <= CNT_W'(LEVEL_BITS - 1);
      end
      U_DIV: begin
        if (!trial[TIME_W+1]) begin
          rem <= trial[TIME_W:0];
          quo <= {quo[LEVEL_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted[TIME_W:0];
          quo <= {quo[LEVEL_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/four_channel_led_fade_engine_top.sv -----
// Top level: command decode, fade sequencer, state registers and result register.
`default_nettype none

// Four-channel LED fade engine. Each beat on cmd is a millisecond tick or a
// command (immediate set, schedule fade, cancel fade, relay); each produces one
// beat on res with the duties, relay drive and fade-armed flag after the item.
// An accepted command is applied in its accept cycle, then the fade is checked
// once. When no fade is running, or it is due to finish, the item passes from
// the check state straight to the done state, which loads the result. While a
// fade is in progress every channel goes through the one shared interpolation
// unit in turn: a multiply step, one bit-serial restoring-divide step per
// quotient bit and a fix-up step. cmd.ready is high only while the sequencer is
// idle. The result sits in its own register, so a new item is taken while an
// earlier result still waits; a second result waits in the sequencer until the
// register frees up. Levels are kept to LEVEL_BITS bits, channels beyond the
// four level fields load zero, and duty fields with no channel behind them
// read zero.

module four_channel_led_fade_engine_top import lfe_pkg::*; #(
  parameter int NUM_CHANNELS = 4,
  parameter int LEVEL_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  lfe_cmd_if.sink   cmd,
  lfe_res_if.source res
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

  lfe_state_t state, state_next;

  // Architectural state
  logic [TIME_W-1:0]     time_now;
  logic                  fade_valid;
  logic [TIME_W-1:0]     fade_begin;
  logic [TIME_W-1:0]     fade_span;
  logic [LEVEL_BITS-1:0] start_lvl [NUM_CHANNELS];
  logic [LEVEL_BITS-1:0] end_lvl   [NUM_CHANNELS];
  logic [LEVEL_BITS-1:0] duty      [NUM_CHANNELS];
  logic                  relay_reg;

  // Sequencer working registers
  logic [CH_W-1:0]       ch;
  logic [TIME_W-1:0]     t_reg;
  logic                  res_valid;

  logic                  unit_start;
  logic                  out_load;
  lfe_unit_sts_t         unit_sts;
  logic [LEVEL_BITS-1:0] unit_result;

  logic [FIELD_W-1:0]    io_lvl  [IO_CHANNELS];
  logic [LEVEL_BITS-1:0] in_lvl  [NUM_CHANNELS];
  logic [FIELD_W-1:0]    out_dty [IO_CHANNELS];

  logic                  accept;
  logic                  reached;
  logic                  finish;
  logic [TIME_W-1:0]     t_now;
  logic [TIME_W:0]       den;

  assign accept = cmd.valid && cmd.ready;

  assign io_lvl[0] = cmd.level_desk_warm;
  assign io_lvl[1] = cmd.level_desk_cold;
  assign io_lvl[2] = cmd.level_ceil_warm;
  assign io_lvl[3] = cmd.level_ceil_cold;

  // Map level fields onto channels; drop the bits above LEVEL_BITS
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_in
    if (g < IO_CHANNELS) begin : g_field
      assign in_lvl[g] = io_lvl[g][LEVEL_BITS-1:0];
    end else begin : g_zero
      assign in_lvl[g] = '0;
    end
  end

  // Duty fields with no channel behind them read zero
  for (genvar g = 0; g < IO_CHANNELS; g++) begin : g_out
    if (g < NUM_CHANNELS) begin : g_duty
      assign out_dty[g] = FIELD_W'(duty[g]);
    end else begin : g_zero
      assign out_dty[g] = '0;
    end
  end

  // Fade check: plain unsigned compare of now against the start, span doubled
  assign reached = (time_now >= fade_begin);
  assign t_now   = time_now - fade_begin;
  assign den     = {fade_span, 1'b0};
  assign finish  = (den == '0) || ({1'b0, t_now} >= den);

  lfe_lerp_unit #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .t_val  (t_reg),
    .den    (den),
    .s_lvl  (start_lvl[ch]),
    .e_lvl  (end_lvl[ch]),
    .sts    (unit_sts),
    .result (unit_result)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (fade_valid && reached && !finish) begin
          state_next = S_MUL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL: state_next = S_WAIT;
      S_WAIT: begin
        if (unit_sts.done) begin
          state_next = (ch == CH_LAST) ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd.ready  = (state == S_IDLE);
    unit_start = (state == S_MUL);
    out_load   = (state == S_DONE) && (!res_valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Architectural state: apply the command on accept, then the fade
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now   <= '0;
      fade_valid <= 1'b0;
      fade_begin <= '0;
      fade_span  <= '0;
      relay_reg  <= 1'b0;
      ch         <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_lvl[i] <= '0;
        end_lvl[i]   <= '0;
        duty[i]      <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.mode)
              MODE_TICK: time_now <= time_now + 1'b1;
              MODE_SET: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                  duty[i]      <= in_lvl[i];
                  start_lvl[i] <= in_lvl[i];
                end
              end
              MODE_SCHED: begin
                fade_valid <= 1'b1;
                fade_begin <= time_now + cmd.delay_ms;
                fade_span  <= cmd.length_ms;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                  end_lvl[i] <= in_lvl[i];
                end
              end
              MODE_CANCEL: fade_valid <= 1'b0;
              MODE_RELAY:  relay_reg  <= cmd.relay_on;
              default: begin
              end
            endcase
          end
        end
        S_CHECK: begin
          ch <= '0;
          if (fade_valid && reached) begin
            if (finish) begin
              // Zero length or elapsed: jump to the end levels and disarm
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                duty[i] <= end_lvl[i];
              end
              fade_valid <= 1'b0;
            end
          end
        end
        S_WAIT: begin
          if (unit_sts.done) begin
            duty[ch] <= unit_result;
            if (ch != CH_LAST) ch <= ch + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold elapsed time steady for the whole interpolation pass
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      t_reg <= t_now;
    end
  end

  // Result register: parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.duty_desk_warm <= out_dty[0];
      res.duty_desk_cold <= out_dty[1];
      res.duty_ceil_warm <= out_dty[2];
      res.duty_ceil_cold <= out_dty[3];
      res.relay_state    <= relay_reg;
      res.fade_armed     <= fade_valid;
    end
  end

  assign res.valid = res_valid;

  // A cancel disarms the fade straight away
  a_cancel_disarms: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.mode == MODE_CANCEL) |=> !fade_valid)
    else $error("fade still armed after cancel");

  // A tick advances time by exactly one
  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.mode == MODE_TICK) |=> (time_now == $past(time_now) + 32'd1))
    else $error("time did not advance on tick");

  // Only a schedule arms the fade
  a_arm_by_sched: assert property (@(posedge clk) disable iff (rst)
    $rose(fade_valid) |-> $past(accept && cmd.mode == MODE_SCHED))
    else $error("fade armed without a schedule");

  // The shared unit stays busy for as long as the sequencer waits on it
  a_unit_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> unit_sts.busy)
    else $error("sequencer waiting on an idle interpolation unit");

  // An interpolated duty lies between its start and end levels
  a_lerp_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && unit_sts.done) |->
      ((unit_result >= start_lvl[ch] && unit_result <= end_lvl[ch]) ||
       (unit_result <= start_lvl[ch] && unit_result >= end_lvl[ch])))
    else $error("interpolated duty outside its fade range");

endmodule

`default_nettype wire
